// ===== rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Holds the parser phase codes, result kinds, the result record and the small
// byte classification helpers.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned DecW  = 25;
  localparam int unsigned SizeW = 31;
  localparam int unsigned MlenW = 32;

  // Parser phase codes.
  localparam logic [3:0] PhHdr     = 4'd0;
  localparam logic [3:0] PhSize    = 4'd1;
  localparam logic [3:0] PhSizeCr  = 4'd2;
  localparam logic [3:0] PhExt     = 4'd3;
  localparam logic [3:0] PhExtCr   = 4'd4;
  localparam logic [3:0] PhData    = 4'd5;
  localparam logic [3:0] PhDataCr  = 4'd6;
  localparam logic [3:0] PhDataLf  = 4'd7;
  localparam logic [3:0] PhTrailer = 4'd8;
  localparam logic [3:0] PhDone    = 4'd9;
  localparam logic [3:0] PhDead    = 4'd10;

  // Result kinds.
  localparam logic [2:0] KindPayload    = 3'd0;
  localparam logic [2:0] KindComplete   = 3'd1;
  localparam logic [2:0] KindMalformed  = 3'd2;
  localparam logic [2:0] KindIncomplete = 3'd3;
  localparam logic [2:0] KindLimit      = 3'd4;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSemi  = 8'h3B;

  localparam logic [DecW-1:0] MaxDecodedReset = DecW'(1024 * 1024);

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [2:0]       kind;
    logic [MlenW-1:0] message_length;
    logic [DecW-1:0]  decoded_length;
    logic             run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] state;
    logic       hit;
  } match_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // One step of the CR LF CR LF matcher.
  function automatic match_t match_step(input logic [1:0] st, input logic [7:0] b);
    match_t r;
    r.hit = 1'b0;
    unique case (st)
      2'd0: r.state = (b == ChCr) ? 2'd1 : 2'd0;
      2'd1: r.state = (b == ChLf) ? 2'd2 : ((b == ChCr) ? 2'd1 : 2'd0);
      2'd2: r.state = (b == ChCr) ? 2'd3 : 2'd0;
      default: begin
        r.hit   = (b == ChLf);
        r.state = (b == ChCr) ? 2'd1 : 2'd0;
      end
    endcase
    return r;
  endfunction

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoding
// Skips the message header, parses chunk-size lines, emits payload bytes and
// reports completion, malformed input, size limit and early end of message.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_ready_o in_byte_i, last_in_i
//   out      output     out_valid_o/out_ready_i out_byte_o, kind_o,
//                                             message_length_o, decoded_length_o,
//                                             run_end_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_max_decoded_bytes_i
//
// One byte is accepted per cycle unless the input stalls; its parser update
// completes in that cycle and its zero to two results enter a four-entry
// result queue, from which they are shown on the output in order.
// The input stalls only when the queue has fewer than two free entries.
// Reset returns the parser to header scan and restores the size limit.
module http_chunked_body_decoder #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic [2:0]                    kind_o,
  output logic [hcbd_pkg::MlenW-1:0]    message_length_o,
  output logic [hcbd_pkg::DecW-1:0]     decoded_length_o,
  output logic                          run_end_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hcbd_pkg::DecW-1:0]     cfg_max_decoded_bytes_i
);
  import hcbd_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;
  localparam int unsigned SumW   = SizeW + 1;

  logic [DecW-1:0]       max_dec_q;
  logic [3:0]            phase_q, phase_d;
  logic [1:0]            crlf_q, crlf_d;
  logic [SizeW-1:0]      size_q, size_d;
  logic                  saw_hex_q, saw_hex_d;
  logic [SizeW-1:0]      remain_q, remain_d;
  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic [DecW-1:0]       dec_q, dec_d;

  logic       accept;
  logic       live;
  logic       pay_valid;
  logic       ev_valid;
  logic [2:0] ev_kind;
  logic       other_valid;
  logic [2:0] other_kind;
  logic [MlenW-1:0] other_mlen;
  match_t     mres;
  hex_t       hres;
  logic [SumW-1:0] limit_sum;
  logic       limit_hit;
  logic [3:0] eol_phase;
  logic       eol_ev;
  logic [2:0] eol_kind;
  logic [1:0] eol_crlf;
  logic [SizeW-1:0] eol_remain;

  result_t    res0, res1;
  logic [1:0] n_push;

  result_t          queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] qcnt_q;
  logic             pop;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign live        = (phase_q != PhDone) && (phase_q != PhDead);
  assign count_inc   = (live && (count_q != '1)) ? count_q + 1'b1 : count_q;
  assign mres        = match_step(crlf_q, in_byte_i);
  assign hres        = hex_value(in_byte_i);
  assign limit_sum   = SumW'(dec_q) + SumW'(size_q);
  assign limit_hit   = limit_sum > SumW'(max_dec_q);

  // Outcome of a finished size line, shared by the plain and extension paths.
  always_comb begin
    eol_phase  = PhData;
    eol_ev     = 1'b0;
    eol_kind   = KindMalformed;
    eol_crlf   = crlf_q;
    eol_remain = remain_q;
    if (!saw_hex_q) begin
      eol_phase = PhDead;
      eol_ev    = 1'b1;
    end else if (size_q == '0) begin
      eol_phase = PhTrailer;
      eol_crlf  = 2'd2;
    end else if (limit_hit) begin
      eol_phase = PhDead;
      eol_ev    = 1'b1;
      eol_kind  = KindLimit;
    end else begin
      eol_remain = size_q;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    crlf_d    = crlf_q;
    size_d    = size_q;
    saw_hex_d = saw_hex_q;
    remain_d  = remain_q;
    count_d   = count_inc;
    dec_d     = dec_q;
    pay_valid = 1'b0;
    ev_valid  = 1'b0;
    ev_kind   = KindMalformed;

    unique case (phase_q)
      PhHdr: begin
        crlf_d = mres.state;
        if (mres.hit) begin
          phase_d   = PhSize;
          size_d    = '0;
          saw_hex_d = 1'b0;
        end
      end
      PhSize: begin
        if (in_byte_i == ChSemi) begin
          phase_d = PhExt;
        end else if (in_byte_i == ChSpace || in_byte_i == ChTab) begin
          phase_d = PhSize;
        end else if (in_byte_i == ChCr) begin
          phase_d = PhSizeCr;
        end else if (!hres.valid || (size_q[SizeW-1:SizeW-4] != 4'd0)) begin
          // Not a digit, or one more digit would pass the largest size.
          phase_d  = PhDead;
          ev_valid = 1'b1;
        end else begin
          size_d    = {size_q[SizeW-5:0], hres.value};
          saw_hex_d = 1'b1;
        end
      end
      PhSizeCr: begin
        if (in_byte_i == ChLf) begin
          phase_d  = eol_phase;
          ev_valid = eol_ev;
          ev_kind  = eol_kind;
          crlf_d   = eol_crlf;
          remain_d = eol_remain;
        end else begin
          phase_d  = PhDead;
          ev_valid = 1'b1;
        end
      end
      PhExt: begin
        if (in_byte_i == ChCr) begin
          phase_d = PhExtCr;
        end
      end
      PhExtCr: begin
        if (in_byte_i == ChLf) begin
          phase_d  = eol_phase;
          ev_valid = eol_ev;
          ev_kind  = eol_kind;
          crlf_d   = eol_crlf;
          remain_d = eol_remain;
        end else if (in_byte_i != ChCr) begin
          phase_d = PhExt;
        end
      end
      PhData: begin
        dec_d     = dec_q + 1'b1;
        pay_valid = 1'b1;
        remain_d  = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
        if (remain_d == '0) begin
          phase_d = PhDataCr;
        end
      end
      PhDataCr: begin
        if (in_byte_i == ChCr) begin
          phase_d = PhDataLf;
        end else begin
          phase_d  = PhDead;
          ev_valid = 1'b1;
        end
      end
      PhDataLf: begin
        if (in_byte_i == ChLf) begin
          phase_d   = PhSize;
          size_d    = '0;
          saw_hex_d = 1'b0;
        end else begin
          phase_d  = PhDead;
          ev_valid = 1'b1;
        end
      end
      PhTrailer: begin
        crlf_d = mres.state;
        if (mres.hit) begin
          phase_d  = PhDone;
          ev_valid = 1'b1;
          ev_kind  = KindComplete;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    // Build the results before the end of message clears the state.
    other_valid = ev_valid
               || (last_in_i && (phase_d != PhDone) && (phase_d != PhDead));
    other_kind  = ev_valid ? ev_kind : KindIncomplete;
    other_mlen  = (ev_valid && (ev_kind == KindComplete)) ? MlenW'(count_inc) : '0;

    res0.out_byte       = pay_valid ? in_byte_i : 8'd0;
    res0.kind           = pay_valid ? KindPayload : other_kind;
    res0.message_length = pay_valid ? '0 : other_mlen;
    res0.decoded_length = dec_d;
    res0.run_end        = !(pay_valid && other_valid);

    res1.out_byte       = 8'd0;
    res1.kind           = other_kind;
    res1.message_length = other_mlen;
    res1.decoded_length = dec_d;
    res1.run_end        = 1'b1;

    n_push = accept ? (2'(pay_valid) + 2'(other_valid)) : 2'd0;

    if (last_in_i) begin
      phase_d   = PhHdr;
      crlf_d    = 2'd0;
      size_d    = '0;
      saw_hex_d = 1'b0;
      remain_d  = '0;
      count_d   = '0;
      dec_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dec_q <= MaxDecodedReset;
      phase_q   <= PhHdr;
      crlf_q    <= 2'd0;
      size_q    <= '0;
      saw_hex_q <= 1'b0;
      remain_q  <= '0;
      count_q   <= '0;
      dec_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_dec_q <= cfg_max_decoded_bytes_i;
      end
      if (accept) begin
        phase_q   <= phase_d;
        crlf_q    <= crlf_d;
        size_q    <= size_d;
        saw_hex_q <= saw_hex_d;
        remain_q  <= remain_d;
        count_q   <= count_d;
        dec_q     <= dec_d;
      end
    end
  end

  // Result queue: up to two pushes and one pop per cycle.
  assign in_ready_o  = qcnt_q <= QCntW'(QDepth - 2);
  assign out_valid_o = qcnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      qcnt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      qcnt_q   <= qcnt_q + QCntW'(n_push) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= res1;
    end
  end

  assign out_byte_o       = queue_q[rd_ptr_q].out_byte;
  assign kind_o           = queue_q[rd_ptr_q].kind;
  assign message_length_o = queue_q[rd_ptr_q].message_length;
  assign decoded_length_o = queue_q[rd_ptr_q].decoded_length;
  assign run_end_o        = queue_q[rd_ptr_q].run_end;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for http_chunked_body_decoder
// Streams HTTP messages into the decoder byte by byte, predicts every payload,
// complete, malformed, incomplete and limit result with an internal parser
// model, and compares each output transaction field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import hcbd_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 80;
  localparam logic [SizeW-1:0] SizeDigitCeiling = 31'h07FF_FFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [7:0]             in_byte_i;
  logic                   last_in_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [7:0]             out_byte_o;
  logic [2:0]             kind_o;
  logic [MlenW-1:0]       message_length_o;
  logic [DecW-1:0]        decoded_length_o;
  logic                   run_end_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [DecW-1:0]        cfg_max_decoded_bytes_i;

  always #5 clk_i = ~clk_i;

  http_chunked_body_decoder uut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .in_byte_i               (in_byte_i),
    .last_in_i               (last_in_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .out_byte_o              (out_byte_o),
    .kind_o                  (kind_o),
    .message_length_o        (message_length_o),
    .decoded_length_o        (decoded_length_o),
    .run_end_o               (run_end_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_max_decoded_bytes_i (cfg_max_decoded_bytes_i)
  );

  result_t    expected_results[$];
  logic [7:0] msg_q[$];
  int         errors;
  int         results_seen;
  int         messages_sent;
  int         live_bytes;
  int         kind_seen[8];
  bit         calm;
  bit         hold_off_req;

  // Parser model state.
  logic [3:0]       prs_phase;
  logic [1:0]       crlf_state;
  logic [SizeW-1:0] size_acc;
  logic             size_has_digit;
  logic [SizeW-1:0] chunk_left;
  logic [31:0]      msg_count;
  logic [DecW-1:0]  body_count;
  logic [DecW-1:0]  size_limit;

  function automatic void clear_parser();
    prs_phase      = PhHdr;
    crlf_state     = 2'd0;
    size_acc       = '0;
    size_has_digit = 1'b0;
    chunk_left     = '0;
    msg_count      = '0;
    body_count     = '0;
  endfunction

  // Tracks CR LF CR LF; returns 1 on the closing LF.
  function automatic logic crlf_advance(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (crlf_state)
      2'd0: crlf_state = (b == ChCr) ? 2'd1 : 2'd0;
      2'd1: crlf_state = (b == ChLf) ? 2'd2 : ((b == ChCr) ? 2'd1 : 2'd0);
      2'd2: crlf_state = (b == ChCr) ? 2'd3 : 2'd0;
      default: begin
        hit = (b == ChLf);
        crlf_state = (!hit && b == ChCr) ? 2'd1 : 2'd0;
      end
    endcase
    return hit;
  endfunction

  function automatic logic hex_digit(input logic [7:0] b, output logic [3:0] v);
    v = '0;
    if (b >= "0" && b <= "9") begin
      v = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      v = 4'(b - "a" + 10);
    end else if (b >= "A" && b <= "F") begin
      v = 4'(b - "A" + 10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void end_of_size_line(output logic fired, output logic [2:0] k);
    fired = 1'b0;
    k     = KindPayload;
    if (!size_has_digit) begin
      prs_phase = PhDead;
      fired     = 1'b1;
      k         = KindMalformed;
    end else if (size_acc == '0) begin
      // The zero chunk's CR LF counts as the first half of the closing match.
      prs_phase  = PhTrailer;
      crlf_state = 2'd2;
    end else if (33'(body_count) + 33'(size_acc) > 33'(size_limit)) begin
      prs_phase = PhDead;
      fired     = 1'b1;
      k         = KindLimit;
    end else begin
      chunk_left = size_acc;
      prs_phase  = PhData;
    end
  endfunction

  function automatic result_t result_of(input logic [7:0] b, input logic [2:0] k,
                                        input logic [MlenW-1:0] mlen);
    result_t r;
    r.out_byte       = b;
    r.kind           = k;
    r.message_length = mlen;
    r.decoded_length = body_count;
    r.run_end        = 1'b0;
    return r;
  endfunction

  // Advances the parser model by one accepted byte and queues its results.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t    outs[2];
    int         n;
    logic       fired;
    logic [2:0] ev;
    logic [3:0] nib;
    n     = 0;
    fired = 1'b0;
    ev    = KindPayload;
    if (prs_phase != PhDone && prs_phase != PhDead) begin
      live_bytes++;
      if (msg_count != '1) msg_count++;
    end
    case (prs_phase)
      PhHdr: begin
        if (crlf_advance(b)) begin
          prs_phase      = PhSize;
          size_acc       = '0;
          size_has_digit = 1'b0;
        end
      end
      PhSize: begin
        if (b == ChSemi) begin
          prs_phase = PhExt;
        end else if (b == ChCr) begin
          prs_phase = PhSizeCr;
        end else if (b != ChSpace && b != ChTab) begin
          if (!hex_digit(b, nib) || size_acc > SizeDigitCeiling) begin
            prs_phase = PhDead;
            fired     = 1'b1;
            ev        = KindMalformed;
          end else begin
            size_acc       = {size_acc[SizeW-5:0], nib};
            size_has_digit = 1'b1;
          end
        end
      end
      PhSizeCr: begin
        if (b == ChLf) begin
          end_of_size_line(fired, ev);
        end else begin
          prs_phase = PhDead;
          fired     = 1'b1;
          ev        = KindMalformed;
        end
      end
      PhExt: begin
        if (b == ChCr) prs_phase = PhExtCr;
      end
      PhExtCr: begin
        if (b == ChLf) begin
          end_of_size_line(fired, ev);
        end else if (b != ChCr) begin
          prs_phase = PhExt;
        end
      end
      PhData: begin
        body_count = body_count + 1'b1;
        outs[n]    = result_of(b, KindPayload, '0);
        n++;
        if (chunk_left != '0) chunk_left--;
        if (chunk_left == '0) prs_phase = PhDataCr;
      end
      PhDataCr: begin
        if (b == ChCr) begin
          prs_phase = PhDataLf;
        end else begin
          prs_phase = PhDead;
          fired     = 1'b1;
          ev        = KindMalformed;
        end
      end
      PhDataLf: begin
        if (b == ChLf) begin
          prs_phase      = PhSize;
          size_acc       = '0;
          size_has_digit = 1'b0;
        end else begin
          prs_phase = PhDead;
          fired     = 1'b1;
          ev        = KindMalformed;
        end
      end
      PhTrailer: begin
        if (crlf_advance(b)) begin
          prs_phase = PhDone;
          fired     = 1'b1;
          ev        = KindComplete;
        end
      end
      default: ;
    endcase
    if (fired) begin
      outs[n] = result_of(8'h00, ev, (ev == KindComplete) ? msg_count : '0);
      n++;
    end else if (last && prs_phase != PhDone && prs_phase != PhDead) begin
      outs[n] = result_of(8'h00, KindIncomplete, '0);
      n++;
    end
    if (n > 0) outs[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);
    if (last) clear_parser();
  endtask

  // Sends one byte; called right after a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    last_in_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, last);
  endtask

  task automatic add_byte(input logic [7:0] b);
    msg_q.push_back(b);
  endtask

  // Octal 015 is CR.
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic add_random_bytes(input int unsigned n);
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Size line with random case, padding, leading zeros and extension.
  task automatic add_size_line(input int unsigned size);
    int unsigned nibs;
    int unsigned d;
    bit          upper;
    upper = 1'($urandom_range(0, 1));
    repeat ($urandom_range(0, 1)) add_byte($urandom_range(0, 1) ? ChSpace : ChTab);
    repeat ($urandom_range(0, 2)) add_byte("0");
    nibs = 1;
    while (nibs < 8 && (size >> (4 * nibs)) != 0) nibs++;
    for (int i = int'(nibs) - 1; i >= 0; i--) begin
      d = (size >> (4 * i)) & 15;
      // ASCII digit, or letter in the chosen case.
      add_byte(8'(d < 10 ? d + 48 : d + (upper ? 55 : 87)));
    end
    repeat ($urandom_range(0, 1)) add_byte($urandom_range(0, 1) ? ChSpace : ChTab);
    if ($urandom_range(0, 3) == 0) add_text(";k=v");
    add_text("\015\n");
  endtask

  task automatic add_chunk(input int unsigned size);
    add_size_line(size);
    add_random_bytes(size);
    add_text("\015\n");
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
    messages_sent++;
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_message();
  endtask

  task automatic drain_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [DecW-1:0] v);
    drain_input();
    cfg_valid_i             <= 1'b1;
    cfg_max_decoded_bytes_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_limit = v;
    @(posedge clk_i);
  endtask

  task automatic build_random_message();
    int unsigned cut;
    repeat ($urandom_range(0, 12)) begin
      add_byte($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(32, 126)));
    end
    add_text("\015\n\015\n");
    repeat ($urandom_range(0, 3)) begin
      add_chunk($urandom_range(0, 7) == 0 ? $urandom_range(17, 40) : $urandom_range(1, 16));
    end
    add_size_line(0);
    if ($urandom_range(0, 2) == 0) add_text("X-T: 1\015\n");
    add_text("\015\n");
    case ($urandom_range(0, 9))
      0: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        cut = $urandom_range(1, msg_q.size() - 1);
        while (msg_q.size() > cut) void'(msg_q.pop_back());
      end
      2: add_random_bytes($urandom_range(1, 4));
      default: ;
    endcase
  endtask

  task automatic test_wellformed();
    send_text("\015\n\015\n1\015\nA\015\n0\015\n\015\n");
    add_text("GET /x HTTP/1.1\015\nHost: h\015\n\015\n a\t\015\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_random_bytes(8);
    add_text("\015\n0B;e=1\015\n");
    add_random_bytes(11);
    add_text("\015\n0;z\015\nX-T: 1\015\n\015\n");
    send_message();
    // A lone CR inside an extension does not end the line.
    send_text("\015\n\015\n2;a\015b\015\015\nxy\015\n0\015\n\015\nzz");
  endtask

  task automatic test_size_line_faults();
    send_text("\015\n\015\nZ12");
    send_text("\015\n\015\n1\015X\015\n");
    send_text("\015\n\015\n\015\n");
    send_text("\015\n\015\n ;e\015\n");
    send_text("\015\n\015\n80000000\015\n");
    send_text("\015\n\015\n7FFFFFFF\015\n");
  endtask

  task automatic test_chunk_framing();
    send_text("\015\n\015\n1\015\nAB\015\n");
    send_text("\015\n\015\n1\015\nA\015B");
    send_text("\015\n\015\n0\015\nT\015\n\015\n");
  endtask

  task automatic test_early_end();
    send_text("HTTP/1.1 200\015\n");
    send_text("\015\n\015\n1");
    send_text("\015\n\015\n1;x");
    send_text("\015\n\015\n3\015\nab");
    send_text("\015\n\015\n1\015\na");
    send_text("\015\n\015\n0\015\nX");
    send_text("\015");
  endtask

  task automatic test_size_limits();
    write_limit(DecW'(3));
    send_text("\015\n\015\n3\015\nabc\015\n1\015\nd\015\n0\015\n\015\n");
    write_limit('0);
    send_text("\015\n\015\n1\015\n");
    send_text("\015\n\015\n0\015\n\015\n");
    write_limit(DecW'(16777216));
    send_text("\015\n\015\n1000001\015\n");
    send_text("\015\n\015\n1000000\015\nxy");
    write_limit(MaxDecodedReset);
    send_text("\015\n\015\n100001\015\n");
  endtask

  // The receiver stops long enough for the result queue to fill.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    add_text("\015\n\015\n");
    add_chunk(20);
    add_text("0\015\n\015\n");
    send_message();
    in_valid_i <= 1'b0;
    while (hold_off_req) @(posedge clk_i);
  endtask

  task automatic test_random_messages(input int target, input bit quiet);
    int goal;
    int n;
    goal = live_bytes + target;
    calm = quiet;
    n    = 0;
    while (live_bytes < goal) begin
      if (n % 6 == 0) begin
        case ($urandom_range(0, 5))
          0: write_limit(DecW'($urandom_range(0, 16777216)));
          1: write_limit(DecW'(16777216));
          default: write_limit(DecW'($urandom_range(1, 48)));
        endcase
      end
      build_random_message();
      send_message();
      n++;
    end
  endtask

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, kind %0d byte %02h",
                 $time, kind_o, out_byte_o);
      end else begin
        want = expected_results.pop_front();
        compare_field("out_byte", 32'(want.out_byte), 32'(out_byte_o));
        compare_field("kind", 32'(want.kind), 32'(kind_o));
        compare_field("message_length", want.message_length, message_length_o);
        compare_field("decoded_length", 32'(want.decoded_length), 32'(decoded_length_o));
        compare_field("run_end", 32'(want.run_end), 32'(run_end_o));
        results_seen++;
        kind_seen[want.kind]++;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni                  <= 1'b0;
    in_valid_i              <= 1'b0;
    in_byte_i               <= '0;
    last_in_i               <= 1'b0;
    cfg_valid_i             <= 1'b0;
    cfg_max_decoded_bytes_i <= '0;
    size_limit = MaxDecodedReset;
    clear_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wellformed();
    test_size_line_faults();
    test_chunk_framing();
    test_early_end();
    test_size_limits();
    test_backpressure();
    test_random_messages(1100, 1'b0);
    test_random_messages(180, 1'b1);

    drain_input();
    $display("Sent %0d messages with %0d live bytes; checked %0d results.",
             messages_sent, live_bytes, results_seen);
    $display("Payload %0d, complete %0d, malformed %0d, incomplete %0d, limit %0d.",
             kind_seen[KindPayload], kind_seen[KindComplete], kind_seen[KindMalformed],
             kind_seen[KindIncomplete], kind_seen[KindLimit]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
